/* sv/assert_macros.svh */
// assertion macros shared by the rtl files
// every macro samples on clk and is disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge
`define ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("invariant check failed");

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* sv/ffxc_pkg.sv */
package ffxc_pkg;

    // width of the raw length counter
    localparam int LENGTH_WIDTH = 16;
    // width of the length limit register
    localparam int CFG_W = 16;
    localparam logic [CFG_W-1:0] MAX_LEN_RESET = 16'd1024;

    // framing and stuffing codes
    localparam logic [7:0] FLAG_BYTE = 8'h7e;
    localparam logic [7:0] ESC_BYTE  = 8'h7d;
    localparam logic [7:0] ESC_FLAG  = 8'h02;
    localparam logic [7:0] ESC_ESC   = 8'h01;

    // result queue depth, power of two and at least 2
    localparam int FIFO_DEPTH = 4;

    typedef enum logic
    {
        KIND_DATA = 1'b0,
        KIND_END  = 1'b1
    } item_kind_t;

    typedef enum logic [1:0]
    {
        STATUS_GOOD     = 2'd0,
        STATUS_BAD      = 2'd1,
        STATUS_OVERFLOW = 2'd2
    } frame_status_t;

    // one result item
    typedef struct packed
    {
        item_kind_t    kind;
        logic [7:0]    data;
        frame_status_t status;
        logic          last;
    } item_t;

    // up to two results produced by one accepted byte
    typedef struct packed
    {
        logic [1:0] n;
        item_t      it0;
        item_t      it1;
    } push_t;

endpackage

/* sv/ffxc_decode.sv */
`include "assert_macros.svh"

module ffxc_decode
    import ffxc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  logic             accept,
    input  logic [7:0]       rx_byte,
    output push_t            push
);

    localparam int CMP_W = (LENGTH_WIDTH > CFG_W) ? LENGTH_WIDTH : CFG_W;
    localparam logic [CMP_W-1:0] COUNT_MAX = CMP_W'((64'd1 << LENGTH_WIDTH) - 64'd1);

    logic [CFG_W-1:0]        max_len_reg;
    logic                    in_frame_reg, in_frame_next;
    logic                    esc_reg, esc_next;
    logic [7:0]              xor_reg, xor_next;
    logic [LENGTH_WIDTH-1:0] count_reg, count_next;
    logic                    seen_reg, seen_next;

    logic [CMP_W-1:0] cfg_ext;
    logic [CMP_W-1:0] limit;
    logic             at_limit;
    logic [7:0]       xor_esc;
    push_t            res;

    // limit in force is the register clipped to the counter range
    assign cfg_ext  = CMP_W'(max_len_reg);
    assign limit    = (cfg_ext < COUNT_MAX) ? cfg_ext : COUNT_MAX;
    assign at_limit = (CMP_W'(count_reg) >= limit);
    assign xor_esc  = xor_reg ^ ESC_BYTE;

    // per-byte framing, unstuffing and check
    always_comb
    begin
        in_frame_next = in_frame_reg;
        esc_next      = esc_reg;
        xor_next      = xor_reg;
        count_next    = count_reg;
        seen_next     = seen_reg;
        res           = '0;
        res.it0.kind  = KIND_DATA;
        res.it1.kind  = KIND_DATA;

        if (!in_frame_reg)
        begin
            // hunting: a flag opens a frame
            if (rx_byte == FLAG_BYTE)
            begin
                in_frame_next = 1'b1;
                esc_next      = 1'b0;
                xor_next      = 8'h00;
                count_next    = LENGTH_WIDTH'(1);
                seen_next     = 1'b0;
            end
        end
        else if (at_limit)
        begin
            // frame too long: drop it
            res.n          = 2'd1;
            res.it0.kind   = KIND_END;
            res.it0.status = STATUS_OVERFLOW;
            res.it0.last   = 1'b1;
            in_frame_next  = 1'b0;
            esc_next       = 1'b0;
            xor_next       = 8'h00;
            count_next     = '0;
            seen_next      = 1'b0;
        end
        else
        begin
            count_next = count_reg + LENGTH_WIDTH'(1);
            if (esc_reg)
            begin
                esc_next = 1'b0;
                if (rx_byte == ESC_FLAG)
                begin
                    res.n        = 2'd1;
                    res.it0.data = FLAG_BYTE;
                    res.it0.last = 1'b1;
                    xor_next     = xor_reg ^ FLAG_BYTE;
                    seen_next    = 1'b1;
                end
                else if (rx_byte == ESC_ESC)
                begin
                    res.n        = 2'd1;
                    res.it0.data = ESC_BYTE;
                    res.it0.last = 1'b1;
                    xor_next     = xor_esc;
                    seen_next    = 1'b1;
                end
                else
                begin
                    // escape with another byte: the escape passes through
                    res.it0.data = ESC_BYTE;
                    xor_next     = xor_esc;
                    seen_next    = 1'b1;
                    if (rx_byte == ESC_BYTE)
                    begin
                        res.n        = 2'd1;
                        res.it0.last = 1'b1;
                        esc_next     = 1'b1;
                    end
                    else if (rx_byte != FLAG_BYTE)
                    begin
                        res.n        = 2'd2;
                        res.it1.data = rx_byte;
                        res.it1.last = 1'b1;
                        xor_next     = xor_esc ^ rx_byte;
                    end
                    else
                    begin
                        // flag right after the escape closes the frame
                        res.n          = 2'd2;
                        res.it1.kind   = KIND_END;
                        res.it1.status = (xor_esc == 8'h00) ? STATUS_GOOD : STATUS_BAD;
                        res.it1.last   = 1'b1;
                        in_frame_next  = 1'b0;
                        xor_next       = 8'h00;
                        count_next     = '0;
                        seen_next      = 1'b0;
                    end
                end
            end
            else if (rx_byte == ESC_BYTE)
            begin
                esc_next = 1'b1;
            end
            else if (rx_byte != FLAG_BYTE)
            begin
                res.n        = 2'd1;
                res.it0.data = rx_byte;
                res.it0.last = 1'b1;
                xor_next     = xor_reg ^ rx_byte;
                seen_next    = 1'b1;
            end
            else if (!seen_reg)
            begin
                // empty flag pair reopens the frame
                xor_next   = 8'h00;
                count_next = LENGTH_WIDTH'(1);
            end
            else
            begin
                // closing flag
                res.n          = 2'd1;
                res.it0.kind   = KIND_END;
                res.it0.status = (xor_reg == 8'h00) ? STATUS_GOOD : STATUS_BAD;
                res.it0.last   = 1'b1;
                in_frame_next  = 1'b0;
                xor_next       = 8'h00;
                count_next     = '0;
                seen_next      = 1'b0;
            end
        end

        if (!accept)
        begin
            res.n = 2'd0;
        end
    end

    assign push = res;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_LEN_RESET;
        end
        else if (cfg_we)
        begin
            max_len_reg <= cfg_wdata;
        end
    end

    // frame state, updated per accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            esc_reg      <= 1'b0;
            xor_reg      <= 8'h00;
            count_reg    <= '0;
            seen_reg     <= 1'b0;
        end
        else if (accept)
        begin
            in_frame_reg <= in_frame_next;
            esc_reg      <= esc_next;
            xor_reg      <= xor_next;
            count_reg    <= count_next;
            seen_reg     <= seen_next;
        end
    end

    // state consistency
    `ASSERT_IMPL(a_esc_in_frame, esc_reg, in_frame_reg)
    `ASSERT_IMPL(a_hunt_clear, !in_frame_reg, (count_reg == '0) && (xor_reg == 8'h00) && !seen_reg)
    `ASSERT_IMPL(a_frame_counted, in_frame_reg, count_reg != '0)

endmodule

/* sv/ffxc_out_queue.sv */
`include "assert_macros.svh"

module ffxc_out_queue
    import ffxc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  push_t push,
    output logic  room,
    output logic  out_valid,
    input  logic  out_stall,
    output item_t head
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    item_t            q_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [PTR_W-1:0] wr_ptr_1;
    logic             pop;

    // room for the largest burst a byte can cause
    assign room      = (count_reg <= CNT_W'(FIFO_DEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign head      = q_reg[rd_ptr_reg];
    assign pop       = out_valid && !out_stall;
    assign wr_ptr_1  = wr_ptr_reg + PTR_W'(1);

    // pointer and fill bookkeeping
    always_comb
    begin
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.n);
        count_next  = count_reg + CNT_W'(push.n) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0)
        begin
            q_reg[wr_ptr_reg] <= push.it0;
        end
        if (push.n == 2'd2)
        begin
            q_reg[wr_ptr_1] <= push.it1;
        end
    end

    // fill level checks
    `ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_W'(FIFO_DEPTH))
    `ASSERT_IMPL(a_push_room, push.n != 2'd0, count_reg <= CNT_W'(FIFO_DEPTH - 2))
    `ASSERT_NEXT(a_pop_only, pop && (push.n == 2'd0), count_reg == $past(count_reg) - CNT_W'(1))

endmodule

/* sv/flag_frame_unstuff_xor_check_unit.sv */
// flag-delimited frame unstuffer with xor check
// input channel: one raw link byte per transaction (in_valid, in_stall, rx_byte)
// output channel: one result per transaction (out_valid, out_stall, item_kind,
//   data_byte, frame_status, last_of_run); data items carry unstuffed bytes,
//   an end item carries good, mismatch or overflow status
// a raw byte gives zero, one or two results; last_of_run marks its last one
// configuration: cfg_we writes cfg_wdata into the raw length limit
// a result enters the result queue when its byte is accepted and is offered after those ahead of it
// throughput: one byte per cycle while each byte gives at most one result and the
//   receiver does not stall; a byte giving two results drains through the single
//   output port of the four-entry result queue
// in_stall rises while the queue holds more than two results, so a stalled
//   receiver backs up into the input once more than two results are waiting
// reset: hunting for a flag, queue empty, length limit 1024
module flag_frame_unstuff_xor_check_unit
    import ffxc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        item_kind,
    output logic [7:0]  data_byte,
    output logic [1:0]  frame_status,
    output logic        last_of_run
);

    logic  room;
    logic  accept;
    push_t push;
    item_t head;

    // input transaction
    assign in_stall = !room;
    assign accept   = in_valid && room;

    ffxc_decode u_decode
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .rx_byte   (rx_byte),
        .push      (push)
    );

    ffxc_out_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    // result fields
    assign item_kind    = head.kind;
    assign data_byte    = head.data;
    assign frame_status = head.status;
    assign last_of_run  = head.last;

endmodule

/* test/flag_frame_unstuff_xor_check_unit_test.sv */
module flag_frame_unstuff_xor_check_unit_test;
    import ffxc_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 4;
    localparam int RANDOM_PHASES = 4;
    localparam int BYTES_PER_PHASE = 320;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_byte = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        item_kind;
    logic [7:0]  data_byte;
    logic [1:0]  frame_status;
    logic        last_of_run;

    // raw link bytes waiting to be sent, unstuffed items still owed by the block
    logic [7:0] raw_bytes[$];
    item_t      predicted_items[$];

    int idle_pct = 38;
    int hold_asked = 0;
    int hold_served = 0;
    int hold_left = 0;
    bit in_acc = 1'b0;
    bit out_acc = 1'b0;
    int error_count = 0;
    int stuck_cycles = 0;

    // unstuffer state as the testbench sees it
    logic [CFG_W-1:0]        len_limit = MAX_LEN_RESET;
    bit                      in_frame = 1'b0;
    bit                      esc_pend = 1'b0;
    bit                      seen_data = 1'b0;
    logic [7:0]              xor_acc = '0;
    logic [LENGTH_WIDTH-1:0] raw_count = '0;

    always #2 clk = ~clk;

    flag_frame_unstuff_xor_check_unit u_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .item_kind    (item_kind),
        .data_byte    (data_byte),
        .frame_status (frame_status),
        .last_of_run  (last_of_run)
    );

    // open a frame (count 1) or drop back to hunting
    function automatic void frame_reset(bit open);
        in_frame = open;
        esc_pend = 1'b0;
        xor_acc = '0;
        raw_count = open ? LENGTH_WIDTH'(1) : LENGTH_WIDTH'(0);
        seen_data = 1'b0;
    endfunction

    // queue one expected item; data items fold into the running xor
    function automatic void emit_item(item_kind_t kind, logic [7:0] data,
                                      frame_status_t status);
        item_t it;
        it.kind = kind;
        it.data = data;
        it.status = status;
        it.last = 1'b0;
        predicted_items.push_back(it);
        if (kind == KIND_DATA)
        begin
            xor_acc = xor_acc ^ data;
            seen_data = 1'b1;
        end
    endfunction

    // advance the unstuffer by one raw byte and queue the items it yields
    function automatic void unstuff_byte(logic [7:0] b);
        int     n_before;
        longint lim;
        n_before = predicted_items.size();
        lim = (len_limit < (2**LENGTH_WIDTH - 1)) ? len_limit : (2**LENGTH_WIDTH - 1);
        if (!in_frame)
        begin
            if (b == FLAG_BYTE)
                frame_reset(1'b1);
        end
        else if (raw_count >= lim)
        begin
            // length limit hit: drop the frame, flags too
            emit_item(KIND_END, 8'h00, STATUS_OVERFLOW);
            frame_reset(1'b0);
        end
        else
        begin
            raw_count = raw_count + 1'b1;
            if (esc_pend)
            begin
                esc_pend = 1'b0;
                if (b == ESC_FLAG)
                    emit_item(KIND_DATA, FLAG_BYTE, STATUS_GOOD);
                else if (b == ESC_ESC)
                    emit_item(KIND_DATA, ESC_BYTE, STATUS_GOOD);
                else
                begin
                    // escape byte followed by anything else passes through
                    emit_item(KIND_DATA, ESC_BYTE, STATUS_GOOD);
                    if (b == ESC_BYTE)
                        esc_pend = 1'b1;
                    else if (b != FLAG_BYTE)
                        emit_item(KIND_DATA, b, STATUS_GOOD);
                end
            end
            else if (b == ESC_BYTE)
                esc_pend = 1'b1;
            else if (b != FLAG_BYTE)
                emit_item(KIND_DATA, b, STATUS_GOOD);

            // flag: empty pair reopens, otherwise close with the check status
            if (b == FLAG_BYTE)
            begin
                if (!seen_data)
                    frame_reset(1'b1);
                else
                begin
                    emit_item(KIND_END, 8'h00,
                              (xor_acc == 8'h00) ? STATUS_GOOD : STATUS_BAD);
                    frame_reset(1'b0);
                end
            end
        end
        if (predicted_items.size() > n_before)
            predicted_items[predicted_items.size() - 1].last = 1'b1;
    endfunction

    // byte biased toward the framing codes
    function automatic logic [7:0] pick_byte();
        logic [7:0] v;
        case ($urandom_range(11))
            0: v = FLAG_BYTE;
            1: v = ESC_BYTE;
            2: v = ESC_FLAG;
            3: v = ESC_ESC;
            4: v = 8'h00;
            5: v = 8'hff;
            default: v = 8'($urandom);
        endcase
        return v;
    endfunction

    // stuff one frame byte onto the link
    function automatic void send_stuffed(logic [7:0] d);
        if (d == FLAG_BYTE)
        begin
            raw_bytes.push_back(ESC_BYTE);
            raw_bytes.push_back(ESC_FLAG);
        end
        else if (d == ESC_BYTE)
        begin
            raw_bytes.push_back(ESC_BYTE);
            raw_bytes.push_back(ESC_ESC);
        end
        else
            raw_bytes.push_back(d);
    endfunction

    // mostly well-formed frames, some noise and corrupted stuffing
    function automatic void queue_random_traffic(int n);
        int         target;
        int         len;
        logic [7:0] d;
        logic [7:0] chk;
        target = raw_bytes.size() + n;
        while (raw_bytes.size() < target)
        begin
            if ($urandom_range(99) < 15)
            begin
                repeat ($urandom_range(1, 4))
                    raw_bytes.push_back(pick_byte());
            end
            else
            begin
                len = ($urandom_range(15) == 0) ? $urandom_range(13, 40)
                                                : $urandom_range(0, 12);
                chk = 8'h00;
                raw_bytes.push_back(FLAG_BYTE);
                for (int i = 0; i < len; i++)
                begin
                    d = pick_byte();
                    chk = chk ^ d;
                    if ($urandom_range(19) == 0)
                        raw_bytes.push_back(pick_byte());
                    else
                        send_stuffed(d);
                end
                // empty flag pair now and then, otherwise a check byte
                if (len != 0 || $urandom_range(1) == 1)
                    send_stuffed(($urandom_range(3) == 0) ? 8'($urandom) : chk);
                raw_bytes.push_back(FLAG_BYTE);
            end
        end
    endfunction

    // single-cycle write of the length limit
    task automatic set_length_limit(logic [15:0] v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        len_limit = v;
    endtask

    // wait until every byte is sent and every item has come back
    task automatic wait_drained();
        while (raw_bytes.size() != 0 || in_valid)
            @(posedge clk);
        while (predicted_items.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // byte driver, holds a stalled transaction steady
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_acc)
        begin
            if (raw_bytes.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                in_valid <= 1'b1;
                rx_byte <= raw_bytes.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result receiver stall, with an occasional long hold-off
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else if (hold_served != hold_asked)
        begin
            hold_served = hold_served + 1;
            hold_left = HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < idle_pct);
    end

    // monitor: predict on accepted bytes, check accepted results, watchdog
    always @(posedge clk)
    begin
        item_t got;
        item_t want;
        if (!rst_n)
        begin
            in_acc = 1'b0;
            out_acc = 1'b0;
        end
        else
        begin
            in_acc = in_valid && !in_stall;
            out_acc = out_valid && !out_stall;
            if (in_acc)
                unstuff_byte(rx_byte);
            if (out_acc)
            begin
                got.kind = item_kind_t'(item_kind);
                got.data = data_byte;
                got.status = frame_status_t'(frame_status);
                got.last = last_of_run;
                if (predicted_items.size() == 0)
                begin
                    error_count = error_count + 1;
                    if (error_count <= 10)
                        $display("unexpected result: kind %0d data %h status %0d last %0d",
                                 got.kind, got.data, got.status, got.last);
                end
                else
                begin
                    want = predicted_items.pop_front();
                    if (got.kind !== want.kind || got.data !== want.data ||
                        got.status !== want.status || got.last !== want.last)
                    begin
                        error_count = error_count + 1;
                        if (error_count <= 10)
                            $display("mismatch: expected kind %0d data %h status %0d last %0d,",
                                     want.kind, want.data, want.status, want.last,
                                     " got kind %0d data %h status %0d last %0d",
                                     got.kind, got.data, got.status, got.last);
                    end
                end
            end
            if (in_acc || out_acc)
                stuck_cycles = 0;
            else
            begin
                stuck_cycles = stuck_cycles + 1;
                if (stuck_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("TEST FAILED");
                    $finish;
                end
            end
        end
    end

    // reset, directed frames, then random phases over several length limits
    initial
    begin
        int limits[RANDOM_PHASES];
        limits[0] = 16;
        limits[1] = 65535;
        limits[2] = 40;
        limits[3] = $urandom_range(16, 200);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // hunting junk, empty flag pair, both escapes, good check, then
        // doubled escape, escape with plain byte, escape before flag, bad check
        raw_bytes = '{8'h55, ESC_BYTE, FLAG_BYTE, FLAG_BYTE,
                      8'h00, 8'hff, ESC_BYTE, ESC_FLAG, ESC_BYTE, ESC_ESC, 8'hfc,
                      FLAG_BYTE,
                      FLAG_BYTE, ESC_BYTE, ESC_BYTE, ESC_ESC, ESC_BYTE, 8'h55,
                      ESC_BYTE, FLAG_BYTE};
        wait_drained();

        // limit below two: data byte and flag both overflow
        set_length_limit(16'd1);
        raw_bytes = '{FLAG_BYTE, 8'h55, FLAG_BYTE, FLAG_BYTE};
        wait_drained();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            set_length_limit(16'(limits[p]));
            idle_pct = (p == 2) ? 0 : 38;
            if (p == 1)
                hold_asked = hold_asked + 1;
            queue_random_traffic(BYTES_PER_PHASE);
            wait_drained();
        end

        if (error_count == 0 && predicted_items.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
